>>> rtl/sliding_window_source_entropy_defines.svh
// Assertion macros shared by the sliding-window entropy RTL.
// Users must have clk and rst in scope.
`ifndef SLIDING_WINDOW_SOURCE_ENTROPY_DEFINES_SVH
`define SLIDING_WINDOW_SOURCE_ENTROPY_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SWSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define SWSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/swse_pkg.sv
// Shared constants and the elaboration-time fixed-point log2 for the
// sliding-window source entropy block. No dependencies.
`default_nettype none

package swse_pkg;

  localparam int SRC_W    = 32;  // source address field
  localparam int ENT_W    = 20;  // entropy output field
  localparam int DIST_W   = 11;  // distinct-count output field
  localparam int OUT_TD_W = 32;  // output tdata, padded to bytes
  localparam int MANT_W   = 32;  // Q1.31 mantissa in the log unit

  // Fixed-point log2 with fb fraction bits, by repeated squaring.
  function automatic logic [63:0] swse_log2(input logic [63:0] c, input int fb);
    logic [63:0] m;
    logic [63:0] frac;
    int          n;
    n    = 0;
    frac = '0;
    if (c == 64'd0) begin
      return 64'd0;
    end
    while (n < 31 && (c >> (n + 1)) != 64'd0) begin
      n = n + 1;
    end
    m = (c << 31) >> n;
    for (int k = 0; k < fb; k++) begin
      m    = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(n) << fb) | frac;
  endfunction

endpackage

`default_nettype wire

>>> rtl/swse_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module swse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/swse_log.sv
// Iterative c*log2(c) unit: one squaring per cycle, then one multiply.
// Depends on swse_pkg and the assertion macro header.
`default_nettype none
`include "sliding_window_source_entropy_defines.svh"

module swse_log
  import swse_pkg::*;
#(
  parameter int CNT_W         = 11,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        start,
  input  wire logic [CNT_W-1:0]                            cnt,
  output logic                                             done,
  output logic [CNT_W+$clog2(CNT_W)+FRACTION_BITS-1:0]     term
);

  localparam int NW  = $clog2(CNT_W);
  localparam int LW  = NW + FRACTION_BITS;
  localparam int TW  = CNT_W + LW;
  localparam int STW = $clog2(FRACTION_BITS + 1);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_ITER = 3'b010,
    L_MUL  = 3'b100
  } phase_t;

  phase_t                    phase;
  logic [CNT_W-1:0]          c_r;
  logic [NW-1:0]             n_r;
  logic [MANT_W-1:0]         m;
  logic [FRACTION_BITS-1:0]  frac;
  logic [STW-1:0]            step;

  logic [NW-1:0]             n_comb;
  logic [CNT_W+MANT_W-2:0]   c_sh;
  logic [MANT_W-1:0]         m_init;
  logic [2*MANT_W-1:0]       prod;
  logic [MANT_W:0]           sq;

  always_comb begin
    n_comb = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (cnt[i]) begin
        n_comb = NW'(i);
      end
    end
    c_sh   = {cnt, (MANT_W-1)'(0)};
    m_init = MANT_W'(c_sh >> n_comb);
    prod   = (2*MANT_W)'(m) * (2*MANT_W)'(m);
    sq     = prod[2*MANT_W-1:MANT_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        L_IDLE: begin
          if (start) begin
            c_r   <= cnt;
            n_r   <= n_comb;
            m     <= m_init;
            frac  <= '0;
            step  <= '0;
            phase <= L_ITER;
          end
        end
        L_ITER: begin
          // top bit of the square decides the next fraction bit
          if (sq[MANT_W]) begin
            m    <= sq[MANT_W:1];
            frac <= {frac[FRACTION_BITS-2:0], 1'b1};
          end else begin
            m    <= sq[MANT_W-1:0];
            frac <= {frac[FRACTION_BITS-2:0], 1'b0};
          end
          step <= step + STW'(1);
          if (step == STW'(FRACTION_BITS - 1)) begin
            phase <= L_MUL;
          end
        end
        L_MUL: begin
          term  <= TW'(c_r) * TW'({n_r, frac});
          done  <= 1'b1;
          phase <= L_IDLE;
        end
        default: phase <= L_IDLE;
      endcase
    end
  end

  `SWSE_ASSERT_NOW(a_done_after_mul, done, $past(phase == L_MUL), "log done without multiply")
  `SWSE_ASSERT_NEXT(a_start_runs, start && phase == L_IDLE, phase == L_ITER, "log start lost")
  `SWSE_ASSERT_NOW(a_step_range, phase == L_ITER, step < STW'(FRACTION_BITS), "log step overrun")

endmodule

`default_nettype wire

>>> rtl/sliding_window_source_entropy.sv
// Sliding-window source-address entropy, top level.
// Depends on swse_pkg, swse_ram, swse_log and the assertion macro header.
//
//  channel  dir  fields (tdata, low bit up)
//  s_*      in   src_address[31:0]
//  m_*      out  entropy_q16[19:0], distinct_sources[30:20], zero pad [31]
//
// With a full window the divide by WINDOW_SIZE runs D = ceil(S/16)
// reciprocal-multiply steps, where S is the width of the running c*log2(c) sum.
// Filling items give no result. The table scan over the count memory's single
// read port dominates the time per item.
// After reset the count table is cleared; s_tready is low meanwhile. A result
// waiting on m_tready holds only the final emit step.
`default_nettype none
`include "sliding_window_source_entropy_defines.svh"

module sliding_window_source_entropy
  import swse_pkg::*;
#(
  parameter int WINDOW_SIZE   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [SRC_W-1:0]    s_tdata,   // src_address[31:0]
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OUT_TD_W-1:0]      m_tdata    // entropy_q16[19:0], distinct_sources[30:20]
);

  localparam int IW = $clog2(WINDOW_SIZE);
  localparam int CW = $clog2(WINDOW_SIZE + 1);
  localparam int NW = $clog2(CW);
  localparam int TW = CW + NW + FRACTION_BITS;
  localparam int EW = SRC_W + CW;
  localparam logic [63:0] TOTAL =
    64'(WINDOW_SIZE) * swse_log2(64'(WINDOW_SIZE), FRACTION_BITS);
  localparam int SW = $clog2(TOTAL + 64'd1);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_SIZE - 1);

  // divide by WINDOW_SIZE as a multiply by a rounded-up reciprocal, 16 bits a step
  localparam int NCH = (SW + 15) / 16;
  localparam int XW  = NCH * 16;
  localparam int RW  = SW + 1;
  localparam int PW  = XW + RW;
  localparam int QS  = SW + IW;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << QS) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);
  localparam logic [RW-1:0] RECIP = RW'(RECIP64);
  localparam int DW = $clog2(NCH + 1);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LOAD   = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_WR_OLD = 9'b000010000,
    S_WR_NEW = 9'b000100000,
    S_LOG    = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [IW-1:0]    clr_idx, ring_ptr, scan_i, cmp_i;
  logic [CW-1:0]    fill_cnt, distinct;
  logic             full_r, issued_all, rd_valid;
  logic [SRC_W-1:0] new_addr, old_addr;
  logic             old_hit, new_hit, free_hit;
  logic [IW-1:0]    old_idx, new_idx, free_idx;
  logic [CW-1:0]    old_cnt, new_cnt;
  logic [SW-1:0]    sum;
  logic [XW-1:0]    div_x;
  logic [PW-1:0]    acc;
  logic [DW-1:0]    div_cnt;
  logic [1:0]       k;
  logic             lg_pend;
  logic             out_valid;
  logic [ENT_W-1:0] out_ent;
  logic [DIST_W-1:0] out_dist;

  // memories
  logic [SRC_W-1:0] ring_rdata;
  logic             tbl_we;
  logic [IW-1:0]    tbl_waddr;
  logic [EW-1:0]    tbl_wdata, tbl_rdata;
  logic [SRC_W-1:0] rd_addr;
  logic [CW-1:0]    rd_cnt;
  logic             rd_live;

  swse_ram #(.WIDTH(SRC_W), .DEPTH(WINDOW_SIZE)) u_ring (
    .clk   (clk),
    .we    (state == S_LOAD),
    .waddr (ring_ptr),
    .wdata (new_addr),
    .raddr (ring_ptr),
    .rdata (ring_rdata)
  );

  swse_ram #(.WIDTH(EW), .DEPTH(WINDOW_SIZE)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (scan_i),
    .rdata (tbl_rdata)
  );

  assign rd_addr = tbl_rdata[EW-1:CW];
  assign rd_cnt  = tbl_rdata[CW-1:0];
  assign rd_live = (rd_cnt != '0);

  // update decisions
  logic same, old_apply, reuse, insert, old_dies;
  assign same      = full_r && old_hit && new_hit && (old_idx == new_idx);
  assign old_apply = full_r && old_hit && !same;
  assign old_dies  = old_apply && (old_cnt == CW'(1));
  assign reuse     = !new_hit && !free_hit && old_dies;
  assign insert    = !new_hit && (free_hit || reuse);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = clr_idx;
    tbl_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        tbl_we = 1'b1;
      end
      S_WR_OLD: begin
        tbl_we    = old_apply && !reuse;
        tbl_waddr = old_idx;
        tbl_wdata = {old_addr, old_cnt - CW'(1)};
      end
      S_WR_NEW: begin
        if (new_hit) begin
          tbl_we    = !same;
          tbl_waddr = new_idx;
          tbl_wdata = {new_addr, new_cnt + CW'(1)};
        end else begin
          tbl_we    = insert;
          tbl_waddr = free_hit ? free_idx : old_idx;
          tbl_wdata = {new_addr, CW'(1)};
        end
      end
      default: ;
    endcase
  end

  // log unit operand: retire old (-c, +(c-1)), count new (-c, +(c+1))
  logic          lg_start, lg_done;
  logic [CW-1:0] lg_cnt;
  logic [TW-1:0] lg_term;
  logic          new_apply;
  assign new_apply = new_hit && !same;
  assign lg_start  = (state == S_LOG) && !lg_pend;

  always_comb begin
    case (k)
      2'd0:    lg_cnt = old_apply ? old_cnt : '0;
      2'd1:    lg_cnt = old_apply ? old_cnt - CW'(1) : '0;
      2'd2:    lg_cnt = new_apply ? new_cnt : '0;
      default: lg_cnt = new_apply ? new_cnt + CW'(1) : '0;
    endcase
  end

  swse_log #(.CNT_W(CW), .FRACTION_BITS(FRACTION_BITS)) u_log (
    .clk   (clk),
    .rst   (rst),
    .start (lg_start),
    .cnt   (lg_cnt),
    .done  (lg_done),
    .term  (lg_term)
  );

  logic [SW-1:0] sum_upd;
  always_comb begin
    if (k[0]) begin
      sum_upd = sum + SW'(lg_term);
    end else begin
      sum_upd = sum - SW'(lg_term);
    end
  end

  // one 16-bit slice of the dividend times the reciprocal, top slice first
  logic [RW+15:0] div_part;
  assign div_part = (RW+16)'(div_x[XW-1 -: 16]) * (RW+16)'(RECIP);

  logic emit_load;
  assign emit_load = (state == S_EMIT) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_idx == LAST_IDX) state_next = S_IDLE;
      S_IDLE:   if (s_tvalid) state_next = S_LOAD;
      S_LOAD:   state_next = S_SCAN;
      S_SCAN:   if (rd_valid && cmp_i == LAST_IDX) state_next = S_WR_OLD;
      S_WR_OLD: state_next = S_WR_NEW;
      S_WR_NEW: state_next = S_LOG;
      S_LOG: begin
        if (lg_done && k == 2'd3) begin
          state_next = full_r ? S_DIV : S_IDLE;
        end
      end
      S_DIV:    if (div_cnt == DW'(NCH - 1)) state_next = S_EMIT;
      S_EMIT:   if (emit_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      ring_ptr  <= '0;
      fill_cnt  <= '0;
      distinct  <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
      lg_pend   <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
        end
        S_IDLE: begin
          if (s_tvalid) begin
            new_addr <= s_tdata;
            full_r   <= (fill_cnt == CW'(WINDOW_SIZE));
          end
        end
        S_LOAD: begin
          old_addr   <= ring_rdata;
          ring_ptr   <= (ring_ptr == LAST_IDX) ? '0 : ring_ptr + IW'(1);
          if (!full_r) begin
            fill_cnt <= fill_cnt + CW'(1);
          end
          scan_i     <= '0;
          issued_all <= 1'b0;
          rd_valid   <= 1'b0;
          old_hit    <= 1'b0;
          new_hit    <= 1'b0;
          free_hit   <= 1'b0;
        end
        S_SCAN: begin
          rd_valid <= !issued_all;
          cmp_i    <= scan_i;
          if (!issued_all) begin
            if (scan_i == LAST_IDX) begin
              issued_all <= 1'b1;
            end else begin
              scan_i <= scan_i + IW'(1);
            end
          end
          if (rd_valid) begin
            // first live match wins, as does the first free entry
            if (full_r && !old_hit && rd_live && rd_addr == old_addr) begin
              old_hit <= 1'b1;
              old_idx <= cmp_i;
              old_cnt <= rd_cnt;
            end
            if (!new_hit && rd_live && rd_addr == new_addr) begin
              new_hit <= 1'b1;
              new_idx <= cmp_i;
              new_cnt <= rd_cnt;
            end
            if (!free_hit && !rd_live) begin
              free_hit <= 1'b1;
              free_idx <= cmp_i;
            end
          end
        end
        S_WR_OLD: begin
          k <= 2'd0;
        end
        S_WR_NEW: begin
          distinct <= distinct + CW'(insert) - CW'(old_dies);
          lg_pend  <= 1'b0;
        end
        S_LOG: begin
          if (lg_start) begin
            lg_pend <= 1'b1;
          end
          if (lg_done) begin
            sum     <= sum_upd;
            lg_pend <= 1'b0;
            k       <= k + 2'd1;
            div_x   <= XW'((sum_upd > SW'(TOTAL)) ? '0 : SW'(TOTAL) - sum_upd);
            acc     <= '0;
            div_cnt <= '0;
          end
        end
        S_DIV: begin
          acc     <= (acc << 16) + PW'(div_part);
          div_x   <= div_x << 16;
          div_cnt <= div_cnt + DW'(1);
        end
        S_EMIT: begin
          if (emit_load) begin
            out_ent  <= ENT_W'(acc >> QS);
            out_dist <= DIST_W'(distinct);
          end
        end
        default: ;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TD_W-ENT_W-DIST_W)'(0), out_dist, out_ent};

  `SWSE_ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, state == S_LOAD, "accept not loaded")
  `SWSE_ASSERT_NOW(a_result_only_full, $rose(m_tvalid), full_r, "result while window filling")
  `SWSE_ASSERT_NOW(a_distinct_bound, state == S_IDLE, distinct <= fill_cnt, "distinct exceeds fill")

endmodule

`default_nettype wire

>>> bench/tb_sliding_window_source_entropy.sv
// Self-checking bench for sliding_window_source_entropy: drives source addresses,
// predicts window entropy and distinct count, compares every output transaction.
// Depends on swse_pkg and the DUT only.
`timescale 1ns / 100ps

module tb_sliding_window_source_entropy;
  import swse_pkg::*;

  localparam int WIN      = 1024;
  localparam int FB       = 16;
  localparam int N_RANDOM = 500;

  typedef struct packed {
    logic [DIST_W-1:0] distinct;
    logic [ENT_W-1:0]  entropy;
  } ent_result_t;

  typedef struct {
    logic [SRC_W-1:0] addr;
    bit               has_exp;
    ent_result_t      exp;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [SRC_W-1:0]    s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_TD_W-1:0] m_tdata;

  sliding_window_source_entropy #(.WINDOW_SIZE(WIN), .FRACTION_BITS(FB)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predictor state
  logic [SRC_W-1:0] win_ring [WIN];
  logic [SRC_W-1:0] tbl_addr [WIN];
  int unsigned      tbl_cnt  [WIN];
  int               addr_idx [logic [SRC_W-1:0]];
  logic [63:0]      clog_sum;
  int unsigned      fill_cnt;
  int unsigned      ring_ptr;
  int unsigned      n_distinct;
  logic [63:0]      lg_tab [WIN+1];

  ent_result_t pending_results[$];
  int          err_count;
  int          mismatch_count;
  bit          sender_idle;
  bit          receiver_idle;
  bit          long_hold;
  int          hold_cycles;

  function automatic logic [63:0] fx_lg(int unsigned c);
    logic [63:0] m;
    logic [63:0] fr;
    int          n;
    fr = '0;
    n  = 0;
    if (c == 0) return '0;
    while (n < 31 && (c >> (n + 1)) != 0) n++;
    m = (64'(c) << 31) >> n;
    for (int k = 0; k < FB; k++) begin
      m  = (m * m) >> 31;
      fr = fr << 1;
      if (m >= (64'd1 << 32)) begin
        m  = m >> 1;
        fr = fr | 64'd1;
      end
    end
    return (64'(n) << FB) | fr;
  endfunction

  function automatic logic [63:0] cterm(int unsigned c);
    return 64'(c) * lg_tab[c];
  endfunction

  function automatic void adjust_count(int i, int unsigned c);
    clog_sum = clog_sum - cterm(tbl_cnt[i]) + cterm(c);
    if (tbl_cnt[i] == 0 && c != 0) n_distinct++;
    if (tbl_cnt[i] != 0 && c == 0) begin
      n_distinct--;
      addr_idx.delete(tbl_addr[i]);
    end
    tbl_cnt[i] = c;
  endfunction

  // returns 1 with the expected entropy/distinct once the window is full
  function automatic bit predict_entropy(logic [SRC_W-1:0] a, output ent_result_t r);
    bit          full;
    logic [63:0] tot;
    logic [63:0] diff;
    int          e;
    full = fill_cnt >= WIN;
    r    = '0;
    if (full) begin
      if (addr_idx.exists(win_ring[ring_ptr])) begin
        e = addr_idx[win_ring[ring_ptr]];
        adjust_count(e, tbl_cnt[e] - 1);
      end
    end else begin
      fill_cnt++;
    end
    if (addr_idx.exists(a)) begin
      e = addr_idx[a];
      adjust_count(e, tbl_cnt[e] + 1);
    end else begin
      for (int i = 0; i < WIN; i++) begin
        if (tbl_cnt[i] == 0) begin
          tbl_addr[i] = a;
          adjust_count(i, 1);
          addr_idx[a] = i;
          break;
        end
      end
    end
    win_ring[ring_ptr] = a;
    ring_ptr = (ring_ptr + 1) % WIN;
    if (!full) return 0;
    tot  = 64'(WIN) * lg_tab[WIN];
    diff = (tot >= clog_sum) ? tot - clog_sum : 64'd0;
    r.entropy  = ENT_W'(diff / WIN);
    r.distinct = DIST_W'(n_distinct);
    return 1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stalls, plus one long hold counted here
  initial begin
    int n;
    m_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < 3000; hold_cycles++) @(posedge clk);
        long_hold = 1'b0;
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // output checker
  always @(posedge clk) begin
    ent_result_t got;
    ent_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = ent_result_t'(m_tdata[ENT_W+DIST_W-1:0]);
      if (pending_results.size() == 0) begin
        err_count++;
        if (mismatch_count++ < 10) $display("ERROR: unexpected transaction %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.entropy !== want.entropy || got.distinct !== want.distinct) begin
          err_count++;
          if (mismatch_count++ < 10)
            $display("ERROR: entropy exp %0d got %0d, distinct exp %0d got %0d",
                     want.entropy, got.entropy, want.distinct, got.distinct);
        end
      end
    end
  end

  // typed expectation replaces the predicted one where has_exp is set
  task automatic send_item(logic [SRC_W-1:0] a, bit has_exp, ent_result_t exp);
    ent_result_t r;
    int          n;
    if (sender_idle && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 11);
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= a;
    @(posedge clk iff s_tready);
    if (predict_entropy(a, r)) pending_results = {pending_results, has_exp ? exp : r};
  endtask

  task automatic send_addr(logic [SRC_W-1:0] a);
    send_item(a, 1'b0, '0);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // random address: mostly from a small hot pool so counts grow and repeat
  function automatic logic [SRC_W-1:0] pick_addr(int mode);
    case (mode)
      0: return 32'hC0A8_0000 | $urandom_range(0, 7);
      1: return 32'h0A00_0000 | $urandom_range(0, 200);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    stim_row_t   dir_rows[$];
    stim_row_t   row;
    int          mode;

    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    err_count = 0; mismatch_count = 0;
    sender_idle = 1'b1; receiver_idle = 1'b1; long_hold = 1'b0;
    clog_sum = '0; fill_cnt = 0; ring_ptr = 0; n_distinct = 0;
    for (int i = 0; i < WIN; i++) tbl_cnt[i] = 0;
    for (int c = 0; c <= WIN; c++) lg_tab[c] = fx_lg(c);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // fill the window with a single address; one more of it gives zero entropy
    // and a single distinct source
    for (int i = 0; i < WIN; i++) send_addr(32'hFFFF_FFFF);
    row.addr = 32'hFFFF_FFFF; row.has_exp = 1'b1;
    row.exp.distinct = DIST_W'(1); row.exp.entropy = '0;
    dir_rows = {dir_rows, row};
    row.has_exp = 1'b0; row.exp = '0;
    row.addr = 32'h0000_0000; dir_rows = {dir_rows, row};
    row.addr = 32'hFFFF_FFFF; dir_rows = {dir_rows, row};
    row.addr = 32'h8000_0001; dir_rows = {dir_rows, row};
    row.addr = 32'h7FFF_FFFE; dir_rows = {dir_rows, row};
    row.addr = 32'h5555_5555; dir_rows = {dir_rows, row};
    row.addr = 32'hAAAA_AAAA; dir_rows = {dir_rows, row};
    row.addr = 32'h0000_0000; dir_rows = {dir_rows, row};
    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].addr, dir_rows[k].has_exp, dir_rows[k].exp);
    end

    // sender pause until all results are back
    wait_drained();

    // long receiver hold while the sender keeps offering
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++) send_addr(pick_addr(0));
    s_tvalid <= 1'b0;
    wait (!long_hold);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i > N_RANDOM - 200) begin
        sender_idle = 1'b0; receiver_idle = 1'b0;
      end
      mode = $urandom_range(0, 9);
      send_addr(pick_addr(mode < 5 ? 0 : (mode < 8 ? 1 : 2)));
    end

    wait_drained();
    repeat (5000) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
